>>> hw/rtl/mcc_pkg.sv
// Shared types, constants and calendar functions for the millisecond calendar clock.
package mcc_pkg;

  // Field widths of one transaction.
  localparam int SEC_W    = 6;
  localparam int MIN_W    = 6;
  localparam int HOUR_W   = 5;
  localparam int DAY_W    = 5;
  localparam int MONTH_W  = 4;
  localparam int YEAR_W   = 14;
  localparam int ELAPSED_W = 48;
  localparam int SUBSEC_W = 16;

  // Default width of the running millisecond total.
  localparam int MS_TOTAL_WIDTH_DEF = 48;

  // Reset value of the sub-second limit register.
  localparam logic [SUBSEC_W-1:0] SUBSEC_TOP_RST = 16'd999;

  // Last legal values of the time units and calendar limits.
  localparam logic [SEC_W-1:0]   SEC_LAST     = 6'd59;
  localparam logic [MIN_W-1:0]   MIN_LAST     = 6'd59;
  localparam logic [HOUR_W-1:0]  HOUR_LAST    = 5'd23;
  localparam logic [MONTH_W-1:0] MONTH_LAST   = 4'd12;
  localparam logic [YEAR_W-1:0]  YEAR_LAST    = 14'd9999;
  localparam logic [YEAR_W-1:0]  YEAR_FIRST   = 14'd1800;
  localparam logic [YEAR_W-1:0]  YEAR_RST     = 14'd2000;
  localparam logic [DAY_W-1:0]   DAY_FIRST    = 5'd1;
  localparam logic [MONTH_W-1:0] MONTH_FIRST  = 4'd1;

  // Month numbers that are not 31 days long.
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;

  // Divisibility by 25 of a 14-bit year: multiply by the inverse of 25
  // modulo 2^14; the product is small exactly for multiples of 25.
  localparam logic [YEAR_W-1:0] YEAR_INV25   = 14'd7209;
  localparam logic [YEAR_W-1:0] YEAR_DIV25_MAX = 14'd655;

  // Transaction opcodes.
  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } mcc_op_t;

  // Calendar date.
  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } mcc_date_t;

  // One input transaction.
  typedef struct packed {
    mcc_op_t            opcode;
    logic [SEC_W-1:0]   load_second;
    logic [MIN_W-1:0]   load_minute;
    logic [HOUR_W-1:0]  load_hour;
    logic [DAY_W-1:0]   load_day;
    logic [MONTH_W-1:0] load_month;
    logic [YEAR_W-1:0]  load_year;
  } mcc_item_t;

  // One result transaction.
  typedef struct packed {
    logic [SEC_W-1:0]     cur_second;
    logic [MIN_W-1:0]     cur_minute;
    logic [HOUR_W-1:0]    cur_hour;
    logic [DAY_W-1:0]     cur_day;
    logic [MONTH_W-1:0]   cur_month;
    logic [YEAR_W-1:0]    cur_year;
    logic [ELAPSED_W-1:0] elapsed_ms;
    logic                 second_pulse;
    logic                 day_rolled;
  } mcc_result_t;

  // Full Gregorian leap-year rule.
  function automatic logic is_leap(input logic [YEAR_W-1:0] year);
    logic [YEAR_W-1:0] prod;
    logic              div25;
    prod  = year * YEAR_INV25;
    div25 = (prod <= YEAR_DIV25_MAX);
    return (year[1:0] == 2'b00) && (!div25 || (year[3:0] == 4'b0000));
  endfunction

  // Days in a month; month codes outside 1..12 count as 31 days.
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                  input logic [YEAR_W-1:0]  year);
    logic [DAY_W-1:0] len;
    case (month)
      MONTH_FEB: len = is_leap(year) ? 5'd29 : 5'd28;
      MONTH_APR,
      MONTH_JUN,
      MONTH_SEP,
      MONTH_NOV: len = 5'd30;
      default:   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

>>> hw/rtl/mcc_if.sv
// Valid/ready channel interfaces for the clock's input and result transactions.
interface mcc_in_if;
  logic                             valid;
  logic                             ready;
  mcc_pkg::mcc_op_t                 opcode;
  logic [mcc_pkg::SEC_W-1:0]        load_second;
  logic [mcc_pkg::MIN_W-1:0]        load_minute;
  logic [mcc_pkg::HOUR_W-1:0]       load_hour;
  logic [mcc_pkg::DAY_W-1:0]        load_day;
  logic [mcc_pkg::MONTH_W-1:0]      load_month;
  logic [mcc_pkg::YEAR_W-1:0]       load_year;

  modport source (
    output valid, opcode, load_second, load_minute, load_hour, load_day,
           load_month, load_year,
    input  ready
  );
  modport sink (
    input  valid, opcode, load_second, load_minute, load_hour, load_day,
           load_month, load_year,
    output ready
  );
endinterface

interface mcc_out_if;
  logic                             valid;
  logic                             ready;
  logic [mcc_pkg::SEC_W-1:0]        cur_second;
  logic [mcc_pkg::MIN_W-1:0]        cur_minute;
  logic [mcc_pkg::HOUR_W-1:0]       cur_hour;
  logic [mcc_pkg::DAY_W-1:0]        cur_day;
  logic [mcc_pkg::MONTH_W-1:0]      cur_month;
  logic [mcc_pkg::YEAR_W-1:0]       cur_year;
  logic [mcc_pkg::ELAPSED_W-1:0]    elapsed_ms;
  logic                             second_pulse;
  logic                             day_rolled;

  modport source (
    output valid, cur_second, cur_minute, cur_hour, cur_day, cur_month,
           cur_year, elapsed_ms, second_pulse, day_rolled,
    input  ready
  );
  modport sink (
    input  valid, cur_second, cur_minute, cur_hour, cur_day, cur_month,
           cur_year, elapsed_ms, second_pulse, day_rolled,
    output ready
  );
endinterface

>>> hw/rtl/mcc_date_step.sv
// Advances a calendar date by one day, with month and year carries.
module mcc_date_step (
  input  mcc_pkg::mcc_date_t date_cur,
  output mcc_pkg::mcc_date_t date_next
);

  logic [mcc_pkg::DAY_W-1:0] month_len;

  assign month_len = mcc_pkg::month_days(date_cur.month, date_cur.year);

  // Day carries into the month, month into the year; the year wraps past its top.
  always_comb begin
    date_next = date_cur;
    if (date_cur.day >= month_len) begin
      date_next.day = mcc_pkg::DAY_FIRST;
      if (date_cur.month >= mcc_pkg::MONTH_LAST) begin
        date_next.month = mcc_pkg::MONTH_FIRST;
        if (date_cur.year >= mcc_pkg::YEAR_LAST) begin
          date_next.year = mcc_pkg::YEAR_FIRST;
        end else begin
          date_next.year = date_cur.year + 1'b1;
        end
      end else begin
        date_next.month = date_cur.month + 1'b1;
      end
    end else begin
      date_next.day = date_cur.day + 1'b1;
    end
  end

endmodule

>>> hw/rtl/mcc_time_core.sv
// Clock state registers with the tick, carry and load logic for one transaction.
module mcc_time_core #(
  parameter int MS_TOTAL_WIDTH = mcc_pkg::MS_TOTAL_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step_en,
  input  mcc_pkg::mcc_item_t             item,
  input  logic [mcc_pkg::SUBSEC_W-1:0]   subsecond_top,
  output mcc_pkg::mcc_result_t           result
);

  logic [mcc_pkg::SUBSEC_W-1:0] subsec_r, subsec_nxt;
  logic [MS_TOTAL_WIDTH-1:0]    ms_total_r, ms_total_nxt;
  logic [mcc_pkg::SEC_W-1:0]    second_r, second_nxt;
  logic [mcc_pkg::MIN_W-1:0]    minute_r, minute_nxt;
  logic [mcc_pkg::HOUR_W-1:0]   hour_r, hour_nxt;
  mcc_pkg::mcc_date_t           date_r, date_nxt;
  mcc_pkg::mcc_date_t           date_step;
  logic                         pulse;
  logic                         rolled;

  // Next calendar day, used only when the hours wrap.
  mcc_date_step u_date_step (
    .date_cur  (date_r),
    .date_next (date_step)
  );

  // Next state for one transaction: load, or one tick with the carry cascade.
  always_comb begin
    subsec_nxt   = subsec_r;
    ms_total_nxt = ms_total_r;
    second_nxt   = second_r;
    minute_nxt   = minute_r;
    hour_nxt     = hour_r;
    date_nxt     = date_r;
    pulse        = 1'b0;
    rolled       = 1'b0;
    if (item.opcode == mcc_pkg::OP_LOAD) begin
      second_nxt     = item.load_second;
      minute_nxt     = item.load_minute;
      hour_nxt       = item.load_hour;
      date_nxt.day   = item.load_day;
      date_nxt.month = item.load_month;
      date_nxt.year  = item.load_year;
      subsec_nxt     = '0;
    end else begin
      ms_total_nxt = ms_total_r + 1'b1;
      if (subsec_r >= subsecond_top) begin
        subsec_nxt = '0;
        pulse      = 1'b1;
        if (second_r < mcc_pkg::SEC_LAST) begin
          second_nxt = second_r + 1'b1;
        end else begin
          second_nxt = '0;
          if (minute_r < mcc_pkg::MIN_LAST) begin
            minute_nxt = minute_r + 1'b1;
          end else begin
            minute_nxt = '0;
            if (hour_r < mcc_pkg::HOUR_LAST) begin
              hour_nxt = hour_r + 1'b1;
            end else begin
              hour_nxt = '0;
              date_nxt = date_step;
              rolled   = 1'b1;
            end
          end
        end
      end else begin
        subsec_nxt = subsec_r + 1'b1;
      end
    end
  end

  // State registers move only when the transaction is handed to the result stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      subsec_r       <= '0;
      ms_total_r     <= '0;
      second_r       <= '0;
      minute_r       <= '0;
      hour_r         <= '0;
      date_r.day     <= mcc_pkg::DAY_FIRST;
      date_r.month   <= mcc_pkg::MONTH_FIRST;
      date_r.year    <= mcc_pkg::YEAR_RST;
    end else if (step_en) begin
      subsec_r   <= subsec_nxt;
      ms_total_r <= ms_total_nxt;
      second_r   <= second_nxt;
      minute_r   <= minute_nxt;
      hour_r     <= hour_nxt;
      date_r     <= date_nxt;
    end
  end

  // The reported elapsed count is the low bits of the total, zero-extended if narrower.
  generate
    if (MS_TOTAL_WIDTH >= mcc_pkg::ELAPSED_W) begin : g_elapsed_trunc
      assign result.elapsed_ms = ms_total_nxt[mcc_pkg::ELAPSED_W-1:0];
    end else begin : g_elapsed_ext
      assign result.elapsed_ms = {{(mcc_pkg::ELAPSED_W-MS_TOTAL_WIDTH){1'b0}}, ms_total_nxt};
    end
  endgenerate

  assign result.cur_second   = second_nxt;
  assign result.cur_minute   = minute_nxt;
  assign result.cur_hour     = hour_nxt;
  assign result.cur_day      = date_nxt.day;
  assign result.cur_month    = date_nxt.month;
  assign result.cur_year     = date_nxt.year;
  assign result.second_pulse = pulse;
  assign result.day_rolled   = rolled;

endmodule

>>> hw/rtl/millisecond_calendar_clock_unit.sv
// Top level of the millisecond calendar clock: input register, clock core, result register.
//
//   Channel  Dir   Handshake        Carries
//   in_ch    in    valid / ready    opcode (tick or load) and the time and date to load
//   out_ch   out   valid / ready    time and date, elapsed_ms, second_pulse, day_rolled
//   cfg_*    in    cfg_we           subsecond_top (ticks per second minus one)
//
// One transaction per cycle is sustained while the result is taken; a transaction
// passes through the input register, then the result register.
// The whole tick/carry/calendar update is one combinational step between the two registers.
// Reset (rst_n low, synchronous) sets 2000-01-01 00:00:00, clears the counters and
// empties both stages. A stalled result holds the input register; input ready stays
// high while the input stage is empty or moving forward.
module millisecond_calendar_clock_unit #(
  parameter int MS_TOTAL_WIDTH = mcc_pkg::MS_TOTAL_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  mcc_in_if.sink                       in_ch,
  mcc_out_if.source                    out_ch,
  input  logic                         cfg_we,
  input  logic [mcc_pkg::SUBSEC_W-1:0] cfg_wdata
);

  logic                         in_valid_r;
  mcc_pkg::mcc_item_t           item_r;
  logic                         out_valid_r;
  mcc_pkg::mcc_result_t         result_r;
  mcc_pkg::mcc_result_t         result_nxt;
  logic [mcc_pkg::SUBSEC_W-1:0] subsec_top_r;
  logic                         advance;
  logic                         in_fire;

  // Move the input stage forward when the result stage is empty or being drained.
  assign advance      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;
  assign in_fire      = in_ch.valid && in_ch.ready;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      subsec_top_r <= mcc_pkg::SUBSEC_TOP_RST;
    end else if (cfg_we) begin
      subsec_top_r <= cfg_wdata;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_fire) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.opcode      <= in_ch.opcode;
      item_r.load_second <= in_ch.load_second;
      item_r.load_minute <= in_ch.load_minute;
      item_r.load_hour   <= in_ch.load_hour;
      item_r.load_day    <= in_ch.load_day;
      item_r.load_month  <= in_ch.load_month;
      item_r.load_year   <= in_ch.load_year;
    end
  end

  // Clock state and update logic.
  mcc_time_core #(
    .MS_TOTAL_WIDTH (MS_TOTAL_WIDTH)
  ) u_time_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_en       (advance),
    .item          (item_r),
    .subsecond_top (subsec_top_r),
    .result        (result_nxt)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_r <= result_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.cur_second   = result_r.cur_second;
  assign out_ch.cur_minute   = result_r.cur_minute;
  assign out_ch.cur_hour     = result_r.cur_hour;
  assign out_ch.cur_day      = result_r.cur_day;
  assign out_ch.cur_month    = result_r.cur_month;
  assign out_ch.cur_year     = result_r.cur_year;
  assign out_ch.elapsed_ms   = result_r.elapsed_ms;
  assign out_ch.second_pulse = result_r.second_pulse;
  assign out_ch.day_rolled   = result_r.day_rolled;

  // A new day can only start on a completed second.
  a_roll_needs_pulse : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && result_r.day_rolled |-> result_r.second_pulse)
    else $error("day_rolled without second_pulse");

  // A new day starts exactly at midnight.
  a_roll_at_midnight : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && result_r.day_rolled |->
      (result_r.cur_hour == '0) && (result_r.cur_minute == '0) &&
      (result_r.cur_second == '0))
    else $error("day_rolled away from midnight");

  // A load transaction never reports a second or a day boundary.
  a_load_no_flags : assert property (@(posedge clk) disable iff (!rst_n)
    advance && (item_r.opcode == mcc_pkg::OP_LOAD) |=>
      out_valid_r && !result_r.second_pulse && !result_r.day_rolled)
    else $error("load transaction reported a boundary");

endmodule
